// ===== rtl/rmq_pkg.sv =====
// Shared types and fixed constants for the rotation matrix to quaternion block.
// No dependencies; used by the top level and the testbench.
package rmq_pkg;

    localparam int IN_W   = 18;                 // width of one matrix entry
    localparam int OUT_W  = 18;                 // width of one quaternion component
    localparam int N_IN   = 9;                  // matrix entries per beat
    localparam int N_OUT  = 4;                  // quaternion components per beat
    localparam int S_DATA_W = 168;              // 9 x 18 bits, padded to whole bytes
    localparam int M_DATA_W = N_OUT * OUT_W;    // 72 bits, already whole bytes
    localparam int OUT_MAX = 131071;
    localparam int OUT_MIN_MAG = 131072;

    // Branch taken for one matrix.
    typedef enum logic [1:0] {
        BR_TRACE,
        BR_DIAG0,
        BR_DIAG1,
        BR_DIAG2
    } branch_t;

endpackage

// ===== rtl/rmq_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
// Depends on nothing; instantiated by rotation_matrix_to_quaternion.
module rmq_sqrt #(
    parameter int SW = 42,   // radicand width, even
    parameter int LW = 21    // root width, SW / 2
) (
    input  logic          aclk,
    input  logic          ce,
    input  logic [SW-1:0] rad,
    output logic [LW-1:0] root
);

    logic [SW-1:0] rem_reg [LW];
    logic [SW-1:0] res_reg [LW];

    for (genvar j = 0; j < LW; j++) begin : g_stage
        localparam int K = LW - 1 - j;
        logic [SW-1:0] rem_prev, res_prev, bb, trial;
        logic [SW-1:0] rem_next, res_next;

        if (j == 0) begin : g_first
            assign rem_prev = rad;
            assign res_prev = '0;
        end else begin : g_rest
            assign rem_prev = rem_reg[j-1];
            assign res_prev = res_reg[j-1];
        end

        assign bb    = SW'(1) << (2 * K);
        assign trial = res_prev + bb;

        always_comb begin
            if (rem_prev >= trial) begin
                rem_next = rem_prev - trial;
                res_next = (res_prev >> 1) + bb;
            end else begin
                rem_next = rem_prev;
                res_next = res_prev >> 1;
            end
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                rem_reg[j] <= rem_next;
                res_reg[j] <= res_next;
            end
        end
    end

    assign root = res_reg[LW-1][LW-1:0];

endmodule

// ===== rtl/rmq_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
// Depends on nothing; the numerator must stay below den << QW.
module rmq_div #(
    parameter int NW = 38,   // numerator width
    parameter int LW = 21,   // denominator width
    parameter int QW = 17    // quotient width
) (
    input  logic          aclk,
    input  logic          ce,
    input  logic [NW-1:0] num,
    input  logic [LW-1:0] den,
    output logic [QW-1:0] quo
);

    localparam int DW = LW + QW;

    logic [DW-1:0] n_reg [QW];
    logic [LW-1:0] d_reg [QW];
    logic [QW-1:0] q_reg [QW];

    for (genvar j = 0; j < QW; j++) begin : g_stage
        localparam int I = QW - 1 - j;
        logic [DW-1:0] n_prev, shifted, n_next;
        logic [LW-1:0] d_prev;
        logic [QW-1:0] q_prev;
        logic          hit;

        if (j == 0) begin : g_first
            assign n_prev = DW'(num);
            assign d_prev = den;
            assign q_prev = '0;
        end else begin : g_rest
            assign n_prev = n_reg[j-1];
            assign d_prev = d_reg[j-1];
            assign q_prev = q_reg[j-1];
        end

        assign shifted = DW'(d_prev) << I;
        assign hit     = (n_prev >= shifted);
        assign n_next  = hit ? (n_prev - shifted) : n_prev;

        always_ff @(posedge aclk) begin
            if (ce) begin
                n_reg[j] <= n_next;
                d_reg[j] <= d_prev;
                q_reg[j] <= {q_prev[QW-2:0], hit};
            end
        end
    end

    assign quo = q_reg[QW-1];

endmodule

// ===== rtl/rotation_matrix_to_quaternion.sv =====
// Rotation matrix to unit quaternion, fully pipelined.
// Depends on rmq_pkg, rmq_sqrt and rmq_div.
//
// Usage:
//   The slave channel takes one 3x3 matrix per beat (nine signed 18-bit
//   entries, m00 in the lowest bits). The master channel returns one unit
//   quaternion per beat: qw, qx, qy, qz in tdata and the degenerate flag in
//   tuser. A matrix whose radicand is not positive or whose length is zero
//   returns zeros with the flag set.
//   The stages run in order: trace and components, magnitudes and squares,
//   sum of squares, the square root with LW = MW + 1 root bits, the
//   dividend, the dividers with QW = FRAC_BITS + 1 quotient bits and the
//   output register. The square root takes one root bit per stage and each
//   divider one quotient bit per stage, which sets the depth. Throughput is one
//   matrix per cycle: a beat enters every cycle that the pipeline advances.
//   The whole pipeline advances together whenever the output register is
//   empty or being taken. When the receiver stalls with a result waiting,
//   every stage holds, s_tready drops and nothing is lost or repeated.
//   Reset clears all valid bits; data registers are left as they are.
module rotation_matrix_to_quaternion #(
    parameter int FRAC_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // m00, m01, m02, m10, m11, m12, m20, m21, m22 (18 bits each), 6 zero bits
    input  logic [rmq_pkg::S_DATA_W-1:0]  s_tdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // qw, qx, qy, qz (18 bits each)
    output logic [rmq_pkg::M_DATA_W-1:0]  m_tdata,
    // degenerate
    output logic                          m_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready
);

    localparam int IW  = rmq_pkg::IN_W;
    localparam int OW  = rmq_pkg::OUT_W;
    localparam int AW  = (FRAC_BITS + 2 > 21) ? FRAC_BITS + 2 : 21;   // signed components
    localparam int MW  = AW - 1;                                      // component magnitude
    localparam int SW  = 2 * MW + 2;                                  // sum of squares
    localparam int LW  = MW + 1;                                      // length
    localparam int QW  = FRAC_BITS + 1;                               // quotient
    localparam int NW  = MW + FRAC_BITS + 1;                          // dividend
    localparam int DEPTH = 5 + LW + QW;
    localparam int ONE_I = 1 << FRAC_BITS;
    localparam int HI    = (ONE_I < rmq_pkg::OUT_MAX) ? ONE_I : rmq_pkg::OUT_MAX;
    localparam int LO_M  = (ONE_I < rmq_pkg::OUT_MIN_MAG) ? ONE_I : rmq_pkg::OUT_MIN_MAG;
    localparam logic signed [AW-1:0] ONE = AW'(64'd1 << FRAC_BITS);

    // advance the whole pipeline when the output slot frees up
    logic ce;
    assign ce       = !m_tvalid || m_tready;
    assign s_tready = ce;

    logic [DEPTH-1:0] vld_reg, vld_next;
    assign vld_next = {vld_reg[DEPTH-2:0], s_tvalid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (ce) begin
            vld_reg <= vld_next;
        end
    end
    assign m_tvalid = vld_reg[DEPTH-1];

    // ---------------- stage 1: trace, branch, raw components ----------------
    logic signed [AW-1:0] m [rmq_pkg::N_IN];
    for (genvar i = 0; i < rmq_pkg::N_IN; i++) begin : g_in
        assign m[i] = AW'($signed(s_tdata[IW*i +: IW]));
    end

    logic signed [AW-1:0] tr, d0, d1, d2;
    logic signed [AW-1:0] a_next [rmq_pkg::N_OUT];
    logic                 bad1_next;
    rmq_pkg::branch_t     br;

    assign tr = m[0] + m[4] + m[8];
    assign d0 = ONE + m[0] - m[4] - m[8];
    assign d1 = ONE + m[4] - m[0] - m[8];
    assign d2 = ONE + m[8] - m[4] - m[0];

    always_comb begin
        priority if (tr > 0)                        br = rmq_pkg::BR_TRACE;
        else if (m[0] > m[4] && m[0] > m[8])        br = rmq_pkg::BR_DIAG0;
        else if (m[4] > m[8])                       br = rmq_pkg::BR_DIAG1;
        else                                        br = rmq_pkg::BR_DIAG2;
    end

    // transposed index convention: x from m12-m21 and so on
    always_comb begin
        unique case (br)
            rmq_pkg::BR_TRACE: begin
                a_next[0] = tr + ONE;
                a_next[1] = m[5] - m[7];
                a_next[2] = m[6] - m[2];
                a_next[3] = m[1] - m[3];
                bad1_next = 1'b0;
            end
            rmq_pkg::BR_DIAG0: begin
                a_next[0] = m[5] - m[7];
                a_next[1] = d0;
                a_next[2] = m[3] + m[1];
                a_next[3] = m[6] + m[2];
                bad1_next = !(d0 > 0);
            end
            rmq_pkg::BR_DIAG1: begin
                a_next[0] = m[6] - m[2];
                a_next[1] = m[3] + m[1];
                a_next[2] = d1;
                a_next[3] = m[7] + m[5];
                bad1_next = !(d1 > 0);
            end
            default: begin
                a_next[0] = m[1] - m[3];
                a_next[1] = m[6] + m[2];
                a_next[2] = m[5] + m[7];
                a_next[3] = d2;
                bad1_next = !(d2 > 0);
            end
        endcase
    end

    logic signed [AW-1:0] a_reg [rmq_pkg::N_OUT];
    logic                 bad1_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            a_reg    <= a_next;
            bad1_reg <= bad1_next;
        end
    end

    // ---------------- stage 2: magnitudes and squares ----------------
    logic [MW-1:0]   mag2_reg [rmq_pkg::N_OUT];
    logic [2*MW-1:0] sq2_reg  [rmq_pkg::N_OUT];
    logic [3:0]      neg2_reg;
    logic            bad2_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int i = 0; i < rmq_pkg::N_OUT; i++) begin
                logic [MW-1:0] mg;
                mg = a_reg[i][AW-1] ? MW'(-a_reg[i]) : MW'(a_reg[i]);
                mag2_reg[i] <= mg;
                sq2_reg[i]  <= mg * mg;
                neg2_reg[i] <= a_reg[i][AW-1];
            end
            bad2_reg <= bad1_reg;
        end
    end

    // ---------------- stage 3: sum of squares ----------------
    logic [SW-1:0] s3_reg;
    logic [MW-1:0] mag3_reg [rmq_pkg::N_OUT];
    logic [3:0]    neg3_reg;
    logic          bad3_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            s3_reg   <= SW'(sq2_reg[0]) + SW'(sq2_reg[1]) + SW'(sq2_reg[2]) + SW'(sq2_reg[3]);
            mag3_reg <= mag2_reg;
            neg3_reg <= neg2_reg;
            bad3_reg <= bad2_reg;
        end
    end

    // ---------------- square root, LW stages ----------------
    logic [LW-1:0] root;

    rmq_sqrt #(.SW(SW), .LW(LW)) u_sqrt (
        .aclk (aclk),
        .ce   (ce),
        .rad  (s3_reg),
        .root (root)
    );

    // hold magnitudes, signs and flag alongside the root
    logic [MW-1:0] mag_dl_reg [LW][rmq_pkg::N_OUT];
    logic [3:0]    neg_dl_reg [LW];
    logic          bad_dl_reg [LW];

    always_ff @(posedge aclk) begin
        if (ce) begin
            mag_dl_reg[0] <= mag3_reg;
            neg_dl_reg[0] <= neg3_reg;
            bad_dl_reg[0] <= bad3_reg;
            for (int j = 1; j < LW; j++) begin
                mag_dl_reg[j] <= mag_dl_reg[j-1];
                neg_dl_reg[j] <= neg_dl_reg[j-1];
                bad_dl_reg[j] <= bad_dl_reg[j-1];
            end
        end
    end

    // ---------------- dividend stage: |a| << F plus half the length ----------------
    logic [NW-1:0] num_reg [rmq_pkg::N_OUT];
    logic [LW-1:0] len_reg;
    logic [3:0]    neg4_reg;
    logic          bad4_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int i = 0; i < rmq_pkg::N_OUT; i++) begin
                num_reg[i] <= (NW'(mag_dl_reg[LW-1][i]) << FRAC_BITS) + NW'(root >> 1);
            end
            len_reg  <= root;
            neg4_reg <= neg_dl_reg[LW-1];
            bad4_reg <= bad_dl_reg[LW-1] || (root == '0);
        end
    end

    // ---------------- dividers, QW stages ----------------
    logic [QW-1:0] quo [rmq_pkg::N_OUT];

    for (genvar i = 0; i < rmq_pkg::N_OUT; i++) begin : g_div
        rmq_div #(.NW(NW), .LW(LW), .QW(QW)) u_div (
            .aclk (aclk),
            .ce   (ce),
            .num  (num_reg[i]),
            .den  (len_reg),
            .quo  (quo[i])
        );
    end

    logic [3:0] neg_dq_reg [QW];
    logic       bad_dq_reg [QW];

    always_ff @(posedge aclk) begin
        if (ce) begin
            neg_dq_reg[0] <= neg4_reg;
            bad_dq_reg[0] <= bad4_reg;
            for (int j = 1; j < QW; j++) begin
                neg_dq_reg[j] <= neg_dq_reg[j-1];
                bad_dq_reg[j] <= bad_dq_reg[j-1];
            end
        end
    end

    // ---------------- output register: sign, saturate, zero on degenerate ----------------
    logic [OW-1:0] q_next [rmq_pkg::N_OUT];

    always_comb begin
        for (int i = 0; i < rmq_pkg::N_OUT; i++) begin
            logic [QW:0] qm;
            logic [OW:0] sm;
            qm = {1'b0, quo[i]};
            if (neg_dq_reg[QW-1][i]) begin
                if (qm > (QW+1)'(LO_M)) qm = (QW+1)'(LO_M);
                sm = (OW+1)'(qm);
                sm = -sm;
            end else begin
                if (qm > (QW+1)'(HI)) qm = (QW+1)'(HI);
                sm = (OW+1)'(qm);
            end
            q_next[i] = bad_dq_reg[QW-1] ? '0 : sm[OW-1:0];
        end
    end

    logic [rmq_pkg::M_DATA_W-1:0] tdata_reg;
    logic                         tuser_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            tdata_reg <= {q_next[3], q_next[2], q_next[1], q_next[0]};
            tuser_reg <= bad_dq_reg[QW-1];
        end
    end

    assign m_tdata = tdata_reg;
    assign m_tuser = tuser_reg;

    // ---------------- checks ----------------
    a_degen_zero : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("degenerate beat with nonzero components");

    a_reset_empty : assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

    a_stall_holds : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_ready_rule : assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready out of step with the output slot");

endmodule

// ===== dv/tb.sv =====
// Testbench for rotation_matrix_to_quaternion: drives matrix beats, predicts each
// quaternion in fixed point and compares field by field. Depends on rmq_pkg and the RTL.
module tb;

    localparam int FRAC     = 16;
    localparam int ONE      = 1 << FRAC;
    localparam int IN_W     = rmq_pkg::IN_W;
    localparam int OUT_W    = rmq_pkg::OUT_W;
    localparam int S_DATA_W = rmq_pkg::S_DATA_W;
    localparam int M_DATA_W = rmq_pkg::M_DATA_W;

    typedef struct {
        logic signed [IN_W-1:0] m [9];
    } matrix_t;

    typedef struct {
        logic signed [OUT_W-1:0] q [4];
        logic                    degenerate;
    } quat_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic [S_DATA_W-1:0]    s_tdata = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [M_DATA_W-1:0]    m_tdata;
    logic                   m_tuser;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;

    matrix_t pending_mats[$];
    quat_t   expected_quats[$];
    int      fail_count = 0;
    bit      stim_done = 1'b0;
    bit      drain_hold = 1'b0;    // sender waits for every result when set
    int      drain_at = 700;       // beat index at which the sender drains once
    int      sent_count = 0;
    int      send_gap = 0;
    int      recv_gap = 0;

    rotation_matrix_to_quaternion #(.FRAC_BITS(FRAC)) u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Integer square root, floor, bit by bit.
    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // Round |a| / len to nearest, apply sign and clamp to [-ONE, ONE].
    function automatic logic signed [OUT_W-1:0] scaled_comp(longint a, longint unsigned len);
        longint unsigned q;
        longint v;
        q = (((a < 0) ? -a : a) << FRAC) + (len >> 1);
        q = q / len;
        if (q > ONE + 1) q = longint'(ONE + 1);
        v = (a < 0) ? -longint'(q) : longint'(q);
        if (v > ONE) v = ONE;
        if (v < -ONE) v = -ONE;
        return v[OUT_W-1:0];
    endfunction

    function automatic quat_t quat_of(matrix_t mt);
        longint m [9];
        longint c [4];
        longint tr;
        longint unsigned sq, len;
        bit bad;
        quat_t r;
        for (int i = 0; i < 9; i++) m[i] = longint'(mt.m[i]);
        tr = m[0] + m[4] + m[8];
        bad = 1'b0;
        if (tr > 0) begin
            c = '{tr + ONE, m[5] - m[7], m[6] - m[2], m[1] - m[3]};
        end else if (m[0] > m[4] && m[0] > m[8]) begin
            c = '{m[5] - m[7], ONE + m[0] - m[4] - m[8], m[3] + m[1], m[6] + m[2]};
            bad = c[1] <= 0;
        end else if (m[4] > m[8]) begin
            c = '{m[6] - m[2], m[3] + m[1], ONE + m[4] - m[0] - m[8], m[7] + m[5]};
            bad = c[2] <= 0;
        end else begin
            c = '{m[1] - m[3], m[6] + m[2], m[5] + m[7], ONE + m[8] - m[4] - m[0]};
            bad = c[3] <= 0;
        end
        sq = 0;
        for (int i = 0; i < 4; i++) sq += longint'(c[i] * c[i]);
        len = root_floor(sq);
        if (len == 0) bad = 1'b1;
        for (int i = 0; i < 4; i++) r.q[i] = bad ? '0 : scaled_comp(c[i], len);
        r.degenerate = bad;
        return r;
    endfunction

    // Keep the low entry bits of an integer.
    function automatic logic signed [IN_W-1:0] ent(int v);
        return IN_W'(v);
    endfunction

    function automatic logic [S_DATA_W-1:0] pack_mat(matrix_t mt);
        logic [S_DATA_W-1:0] d;
        d = '0;
        for (int i = 0; i < 9; i++) d[i*IN_W +: IN_W] = mt.m[i];
        return d;
    endfunction

    function automatic matrix_t mat_all(int v);
        matrix_t mt;
        for (int i = 0; i < 9; i++) mt.m[i] = ent(v);
        return mt;
    endfunction

    // Near-rotation matrix: random entries in [-ONE, ONE], diagonal signs set by a random axis.
    function automatic matrix_t mat_rotlike();
        matrix_t mt;
        int axis, ang;
        axis = $urandom_range(0, 3);
        for (int i = 0; i < 9; i++) mt.m[i] = ent(int'($urandom_range(0, 2 * ONE)) - ONE);
        if (axis < 3) begin
            for (int i = 0; i < 3; i++) mt.m[i*4] = ent(-int'($urandom_range(0, ONE)));
            mt.m[axis*4] = ent($urandom_range(0, ONE));
        end else begin
            for (int i = 0; i < 3; i++) mt.m[i*4] = ent($urandom_range(0, ONE));
        end
        ang = $urandom_range(0, 3);
        if (ang == 0) mt.m[$urandom_range(0, 8)] = ent(($urandom_range(0, 1)) ? ONE : -ONE);
        return mt;
    endfunction

    initial begin
        matrix_t mt;
        // Directed: identity, extremes, each branch, degenerate and zero-length cases.
        mt = mat_all(0); mt.m[0] = ent(ONE); mt.m[4] = ent(ONE); mt.m[8] = ent(ONE);
        pending_mats.push_back(mt);
        pending_mats.push_back(mat_all(0));
        pending_mats.push_back(mat_all(ONE));
        pending_mats.push_back(mat_all(-ONE));
        pending_mats.push_back(mat_all(131071));
        pending_mats.push_back(mat_all(-131072));
        mt = mat_all(0); mt.m[0] = ent(ONE); mt.m[4] = ent(-ONE); mt.m[8] = ent(-ONE);
        pending_mats.push_back(mt);
        mt = mat_all(0); mt.m[0] = ent(-ONE); mt.m[4] = ent(ONE); mt.m[8] = ent(-ONE);
        pending_mats.push_back(mt);
        mt = mat_all(0); mt.m[0] = ent(-ONE); mt.m[4] = ent(-ONE); mt.m[8] = ent(ONE);
        pending_mats.push_back(mt);
        // ties on the diagonal fall to the later entry
        mt = mat_all(0); mt.m[0] = ent(-100); mt.m[4] = ent(-100); mt.m[8] = ent(-100);
        pending_mats.push_back(mt);
        // diagonal branches reached with a trace that is not positive
        mt = mat_all(0); mt.m[0] = ent(-ONE); mt.m[4] = ent(-131072); mt.m[8] = ent(131071);
        pending_mats.push_back(mt);
        mt = mat_all(0); mt.m[0] = ent(0); mt.m[4] = ent(ONE); mt.m[8] = ent(-ONE);
        pending_mats.push_back(mt);
        // diagonal branch with a tie between the last two entries
        mt = mat_all(0); mt.m[4] = ent(-ONE / 2); mt.m[8] = ent(-ONE / 2); mt.m[0] = ent(-ONE);
        pending_mats.push_back(mt);
        mt = mat_all(131071); mt.m[0] = ent(-131072); pending_mats.push_back(mt);
        mt = mat_all(-131072); mt.m[8] = ent(131071); pending_mats.push_back(mt);
        for (int n = 0; n < 1435; n++) begin
            if ($urandom_range(0, 4) == 0) begin
                for (int i = 0; i < 9; i++) mt.m[i] = ent($urandom());
            end else begin
                mt = mat_rotlike();
            end
            pending_mats.push_back(mt);
        end
    end

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // Driver: present one matrix per beat, with a random gap after each.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                expected_quats.push_back(quat_of(pending_mats.pop_front()));
                sent_count++;
                send_gap = $urandom_range(0, 13);
                if (sent_count == drain_at) drain_hold = 1'b1;
            end
            if (drain_hold && expected_quats.size() == 0) drain_hold = 1'b0;
            if (s_tvalid && !s_tready) begin
                // hold the beat until taken
            end else if (pending_mats.size() == 0) begin
                s_tvalid  <= 1'b0;
                stim_done <= 1'b1;
            end else if (drain_hold || send_gap > 0) begin
                s_tvalid <= 1'b0;
                if (send_gap > 0) send_gap--;
            end else begin
                s_tvalid <= 1'b1;
                s_tdata  <= pack_mat(pending_mats[0]);
            end
        end
    end

    // Monitor: random backpressure; compare each taken beat with the oldest prediction.
    always @(posedge aclk) begin
        quat_t exp_q;
        logic signed [OUT_W-1:0] got;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_quats.size() == 0) begin
                    $error("unexpected result beat");
                    fail_count++;
                end else begin
                    exp_q = expected_quats.pop_front();
                    for (int i = 0; i < 4; i++) begin
                        got = m_tdata[i*OUT_W +: OUT_W];
                        if (got !== exp_q.q[i]) begin
                            $error("q%0s expected %0d actual %0d",
                                   i == 0 ? "w" : i == 1 ? "x" : i == 2 ? "y" : "z",
                                   exp_q.q[i], got);
                            fail_count++;
                        end
                    end
                    if (m_tuser !== exp_q.degenerate) begin
                        $error("degenerate expected %0d actual %0d", exp_q.degenerate, m_tuser);
                        fail_count++;
                    end
                end
                recv_gap = $urandom_range(0, 13);
            end else if (recv_gap > 0) begin
                recv_gap--;
            end
            m_tready <= (recv_gap == 0);
        end
    end

    initial begin
        wait (stim_done);
        wait (expected_quats.size() == 0);
        repeat (100) @(posedge aclk);
        if (fail_count == 0 && expected_quats.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #4000000;
        $display("status: fail");
        $finish;
    end
endmodule

// ===== rotation_matrix_to_quaternion.f =====
rtl/rmq_pkg.sv
rtl/rmq_sqrt.sv
rtl/rmq_div.sv
rtl/rotation_matrix_to_quaternion.sv
dv/tb.sv
